/* design/md4_pkg.sv */
// ============================================================================
// MD4 single-block digest package
// Shared types, constants and per-step tables for the MD4 pipeline cells.
// ============================================================================
package md4_pkg;

    // Message and block geometry.
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned MSG_WORDS = 8;
    localparam int unsigned MSG_BYTES = 32;
    localparam int unsigned LEN_W     = 5;
    localparam int unsigned LEN_WORD  = 14;
    localparam int unsigned NUM_STEPS = 48;
    localparam int unsigned STEPS_PER_ROUND = 16;

    // Stream widths: eight words plus the length, padded to whole bytes.
    localparam int unsigned S_TDATA_W = 264;
    localparam int unsigned M_TDATA_W = 128;

    // Initial chaining values and round constants.
    localparam logic [31:0] IV_A    = 32'h67452301;
    localparam logic [31:0] IV_B    = 32'hefcdab89;
    localparam logic [31:0] IV_C    = 32'h98badcfe;
    localparam logic [31:0] IV_D    = 32'h10325476;
    localparam logic [31:0] K_ROUND2 = 32'h5a827999;
    localparam logic [31:0] K_ROUND3 = 32'h6ed9eba1;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    // Round codes.
    localparam int unsigned ROUND_F = 0;
    localparam int unsigned ROUND_G = 1;
    localparam int unsigned ROUND_H = 2;

    // One item travelling down the chain: working state (word 0 is the one
    // updated next), padded message words and the byte length.
    typedef struct packed {
        logic [3:0][WORD_W-1:0]    st;
        logic [MSG_WORDS-1:0][WORD_W-1:0] blk;
        logic [LEN_W-1:0]          len;
    } item_t;

    // Index of the block word consumed by a given step.
    function automatic logic [3:0] msg_index(input int unsigned step);
        logic [3:0] i;
        logic [3:0] idx;
        i = 4'(step % STEPS_PER_ROUND);
        case (step / STEPS_PER_ROUND)
            ROUND_F: idx = i;
            ROUND_G: idx = {i[1:0], i[3:2]};
            default: idx = {i[0], i[1], i[2], i[3]};
        endcase
        return idx;
    endfunction

    // Left-rotate amount of a given step.
    function automatic logic [4:0] shift_amt(input int unsigned step);
        logic [1:0] j;
        logic [4:0] s;
        j = 2'(step % 4);
        case (step / STEPS_PER_ROUND)
            ROUND_F: begin
                case (j)
                    2'd0:    s = 5'd3;
                    2'd1:    s = 5'd7;
                    2'd2:    s = 5'd11;
                    default: s = 5'd19;
                endcase
            end
            ROUND_G: begin
                case (j)
                    2'd0:    s = 5'd3;
                    2'd1:    s = 5'd5;
                    2'd2:    s = 5'd9;
                    default: s = 5'd13;
                endcase
            end
            default: begin
                case (j)
                    2'd0:    s = 5'd3;
                    2'd1:    s = 5'd9;
                    2'd2:    s = 5'd11;
                    default: s = 5'd15;
                endcase
            end
        endcase
        return s;
    endfunction

    // Additive constant of a given step.
    function automatic logic [31:0] round_const(input int unsigned step);
        logic [31:0] k;
        case (step / STEPS_PER_ROUND)
            ROUND_F: k = 32'd0;
            ROUND_G: k = K_ROUND2;
            default: k = K_ROUND3;
        endcase
        return k;
    endfunction

endpackage

/* design/md4_single_block_digest_top.sv */
// ============================================================================
// MD4 single-block digest top level
// Chain of a padding cell, 48 step cells and an output register.
// ============================================================================
// Usage:
// The slave channel takes one message per beat: eight 32-bit words holding
// up to 31 bytes little-endian, and a 5-bit byte length. The master channel
// returns one beat per message carrying the four MD4 digest words.
// An accepted input beat is registered in turn in the padding cell, in a
// row of 48 step cells (one per MD4 step), and in the output register that
// adds the chaining values; m_tvalid then rises.
// Throughput is one message per cycle while m_tready stays high; every cell
// holds one message and hands it to its neighbor each cycle it is not stalled.
// Each cell moves on whenever its neighbor is empty or moving, so a stalled
// receiver freezes only the full end of the chain; input beats keep filling
// empty cells until all 50 stages hold a message, and s_tready drops then.
// Reset clears every valid bit; the chain is empty and s_tready is high in
// the first cycle after reset.
// ============================================================================
module md4_single_block_digest_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Fields from bit 0 up: msg_word0 .. msg_word7, msg_len, zero fill.
    input  logic [md4_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // Fields from bit 0 up: digest_a, digest_b, digest_c, digest_d.
    output logic [md4_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready
);

    localparam int unsigned Steps = md4_pkg::NUM_STEPS;

    logic [md4_pkg::MSG_WORDS-1:0][md4_pkg::WORD_W-1:0] in_words;
    logic [md4_pkg::LEN_W-1:0] in_len;

    md4_pkg::item_t chain_item  [0:Steps];
    logic           chain_valid [0:Steps];
    logic           chain_ready [0:Steps];

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [md4_pkg::M_TDATA_W-1:0] out_data_reg;
    logic [md4_pkg::M_TDATA_W-1:0] out_data_next;
    logic                          out_load;

    // Unpack the input beat.
    assign in_words = s_tdata[md4_pkg::MSG_WORDS*md4_pkg::WORD_W-1:0];
    assign in_len   = s_tdata[md4_pkg::MSG_WORDS*md4_pkg::WORD_W +: md4_pkg::LEN_W];

    // Padding cell heads the chain.
    md4_pad u_pad (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_words  (in_words),
        .in_len    (in_len),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_item  (chain_item[0])
    );

    // One cell per MD4 step.
    for (genvar g = 0; g < Steps; g++) begin : g_step
        md4_step_cell #(
            .STEP_IDX (g)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[g]),
            .in_ready  (chain_ready[g]),
            .in_item   (chain_item[g]),
            .out_valid (chain_valid[g+1]),
            .out_ready (chain_ready[g+1]),
            .out_item  (chain_item[g+1])
        );
    end

    // Output register: add back the chaining values.
    assign chain_ready[Steps] = !out_valid_reg || m_tready;
    assign out_load           = chain_valid[Steps] && chain_ready[Steps];

    always_comb begin
        out_data_next = {chain_item[Steps].st[3] + md4_pkg::IV_D,
                         chain_item[Steps].st[2] + md4_pkg::IV_C,
                         chain_item[Steps].st[1] + md4_pkg::IV_B,
                         chain_item[Steps].st[0] + md4_pkg::IV_A};
        out_valid_next = chain_ready[Steps] ? chain_valid[Steps] : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

/* design/md4_pad.sv */
// ============================================================================
// MD4 padding cell
// First cell of the chain: masks bytes past the length, places the pad byte
// and loads the initial chaining values.
// ============================================================================
module md4_pad (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [md4_pkg::MSG_WORDS-1:0][md4_pkg::WORD_W-1:0] in_words,
    input  logic [md4_pkg::LEN_W-1:0]              in_len,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output md4_pkg::item_t                         out_item
);

    logic           valid_reg;
    logic           valid_next;
    md4_pkg::item_t item_reg;
    md4_pkg::item_t item_next;

    // Build the padded message words byte by byte.
    always_comb begin
        logic [md4_pkg::LEN_W-1:0] pos;
        logic [7:0]                byte_in;
        item_next.st  = {md4_pkg::IV_D, md4_pkg::IV_C, md4_pkg::IV_B, md4_pkg::IV_A};
        item_next.len = in_len;
        item_next.blk = '0;
        for (int k = 0; k < md4_pkg::MSG_BYTES; k++) begin
            pos     = md4_pkg::LEN_W'(k);
            byte_in = in_words[k / 4][(k % 4) * 8 +: 8];
            if (pos < in_len) begin
                item_next.blk[k / 4][(k % 4) * 8 +: 8] = byte_in;
            end else if (pos == in_len) begin
                item_next.blk[k / 4][(k % 4) * 8 +: 8] = md4_pkg::PAD_BYTE;
            end else begin
                item_next.blk[k / 4][(k % 4) * 8 +: 8] = 8'd0;
            end
        end
    end

    // The cell takes a beat when empty or when its contents move on.
    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

/* design/md4_step_cell.sv */
// ============================================================================
// MD4 step cell
// One MD4 step: updates the leading state word and rotates the state so the
// next cell again updates word 0.
// ============================================================================
module md4_step_cell #(
    parameter int unsigned STEP_IDX = 0
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  md4_pkg::item_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output md4_pkg::item_t out_item
);

    localparam logic [3:0]  WordIdx = md4_pkg::msg_index(STEP_IDX);
    localparam logic [4:0]  RotAmt  = md4_pkg::shift_amt(STEP_IDX);
    localparam logic [31:0] StepK   = md4_pkg::round_const(STEP_IDX);
    localparam int unsigned Round   = STEP_IDX / md4_pkg::STEPS_PER_ROUND;

    logic           valid_reg;
    logic           valid_next;
    md4_pkg::item_t item_reg;
    md4_pkg::item_t item_next;
    logic [31:0]    x_word;
    logic [31:0]    fn_val;
    logic [31:0]    sum;
    logic [31:0]    rot;

    // Block word for this step; words past the message are zero except
    // the bit-length word.
    always_comb begin
        if (WordIdx < 4'(md4_pkg::MSG_WORDS)) begin
            x_word = in_item.blk[WordIdx[2:0]];
        end else if (WordIdx == 4'(md4_pkg::LEN_WORD)) begin
            x_word = {24'd0, in_item.len, 3'd0};
        end else begin
            x_word = 32'd0;
        end
    end

    // Round function on words 1 to 3.
    always_comb begin
        case (Round)
            md4_pkg::ROUND_F: fn_val = (in_item.st[1] & in_item.st[2]) |
                                       (~in_item.st[1] & in_item.st[3]);
            md4_pkg::ROUND_G: fn_val = (in_item.st[1] & in_item.st[2]) |
                                       (in_item.st[1] & in_item.st[3]) |
                                       (in_item.st[2] & in_item.st[3]);
            default:          fn_val = in_item.st[1] ^ in_item.st[2] ^ in_item.st[3];
        endcase
    end

    // Step sum, rotate, and state rotation (a, b, c, d) -> (d, a', b, c).
    always_comb begin
        sum = in_item.st[0] + fn_val + x_word + StepK;
        rot = (sum << RotAmt) | (sum >> (6'd32 - {1'b0, RotAmt}));
        item_next       = in_item;
        item_next.st[0] = in_item.st[3];
        item_next.st[1] = rot;
        item_next.st[2] = in_item.st[1];
        item_next.st[3] = in_item.st[2];
    end

    // The cell takes a beat when empty or when its contents move on.
    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

/* design/md4_checker.sv */
// ============================================================================
// MD4 digest port checker
// Watches the top level's ports for reset behavior, flow and output holding.
// ============================================================================
module md4_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic [md4_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready
);

    // After reset the chain is empty: nothing to send, room to accept.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && s_tready))
        else $error("chain not empty after reset");

    // With the output register empty, every cell can move, so input flows.
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output is empty");

    // A beat taken by the receiver frees the output stage, so the input
    // side cannot be blocked in that cycle.
    a_ready_on_take: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready) |-> s_tready)
        else $error("input stalled while output beat is taken");

    // A stalled digest holds its value.
    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled output beat changed");

endmodule

bind md4_single_block_digest_top md4_checker u_md4_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
